FILE: rtl/rled_pkg.sv
// Package for the RLE pixel stream LED matrix driver.
// Types, constants and the lamp map; no dependencies.
`timescale 1ns / 1ps
package rled_pkg;

    localparam int PanelRows    = 8;
    localparam int PanelColumns = 8;
    localparam int CfgIdxW      = 3;
    localparam int CfgDataW     = 8;

    localparam logic [CfgIdxW-1:0] REG_SYNC_FIRST  = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_SYNC_SECOND = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_SYNC_THIRD  = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_GRID_COLS   = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_GRID_ROWS   = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_BOARD_COL   = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_BOARD_ROW   = 3'd6;

    localparam logic [14:0] RedMask   = 15'h7C00;
    localparam logic [14:0] GreenMask = 15'h03E0;
    localparam logic [14:0] BlueMask  = 15'h001F;
    localparam logic [4:0]  CompMask  = 5'h1F;

    typedef enum logic [2:0] {
        LINK_WAIT  = 3'd0,
        LINK_SYNC1 = 3'd1,
        LINK_SYNC2 = 3'd2,
        LINK_BYTE0 = 3'd3,
        LINK_BYTE1 = 3'd4,
        LINK_BYTE2 = 3'd5
    } link_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAINT,
        ST_SCAN_RD,
        ST_SCAN_PX,
        ST_OUT
    } seq_t;

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] row_drive;
        logic [7:0] shift_first;
        logic [7:0] shift_second;
        logic [7:0] shift_third;
        logic       row_lit;
    } out_item_t;

    typedef struct packed {
        logic [7:0] sync_first;
        logic [7:0] sync_second;
        logic [7:0] sync_third;
        logic [7:0] grid_columns;
        logic [7:0] grid_rows;
        logic [7:0] board_column_offset;
        logic [7:0] board_row_offset;
    } cfg_t;

    // lamp bit for column*3+colour: {which byte (2 bits), bit number (3 bits)}
    function automatic logic [4:0] lamp_map(input logic [4:0] idx);
        logic [4:0] r;
        case (idx)
            5'd0:  r = {2'd2, 3'd0};
            5'd1:  r = {2'd2, 3'd1};
            5'd2:  r = {2'd1, 3'd3};
            5'd3:  r = {2'd1, 3'd2};
            5'd4:  r = {2'd1, 3'd1};
            5'd5:  r = {2'd2, 3'd2};
            5'd6:  r = {2'd2, 3'd3};
            5'd7:  r = {2'd2, 3'd4};
            5'd8:  r = {2'd1, 3'd0};
            5'd9:  r = {2'd0, 3'd7};
            5'd10: r = {2'd0, 3'd6};
            5'd11: r = {2'd2, 3'd5};
            5'd12: r = {2'd2, 3'd6};
            5'd13: r = {2'd0, 3'd5};
            5'd14: r = {2'd2, 3'd7};
            5'd15: r = {2'd0, 3'd4};
            5'd16: r = {2'd1, 3'd7};
            5'd17: r = {2'd0, 3'd3};
            5'd18: r = {2'd1, 3'd6};
            5'd19: r = {2'd0, 3'd2};
            5'd20: r = {2'd1, 3'd5};
            5'd21: r = {2'd0, 3'd1};
            5'd22: r = {2'd1, 3'd4};
            5'd23: r = {2'd0, 3'd0};
            default: r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/rle_pixel_stream_led_matrix_driver_unit.sv
// Top level of the RLE pixel stream LED matrix driver: link parser, run
// painter and row scanner around one pixel store. Depends on rled_pkg and rled_cfg_regs.
//
//   channel | signals                          | direction
//   in      | in_valid, in_stall, in_data      | item in
//   out     | out_valid, out_stall, out_data   | result out
//   cfg     | cfg_write, cfg_index, cfg_data   | register write
//
// A run (up to 255 pixels) is painted through the single pointer/window unit
// and the store write port.
// A refresh tick reads the store once per column through a shared compare, then
// waits in ST_OUT while a held result still occupies the output register.
// Reset clears the 64-entry store with valid bits; no clearing pass.
// Input is stalled while busy; a held result alone does not stall it.
`timescale 1ns / 1ps
module rle_pixel_stream_led_matrix_driver_unit
#(
    parameter int PANEL_ROWS    = rled_pkg::PanelRows,
    parameter int PANEL_COLUMNS = rled_pkg::PanelColumns
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  rled_pkg::in_item_t            in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output rled_pkg::out_item_t           out_data,
    input  logic                          cfg_write,
    input  logic [rled_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [rled_pkg::CfgDataW-1:0] cfg_data
);
    import rled_pkg::*;

    localparam int Depth = PANEL_ROWS * PANEL_COLUMNS;
    localparam int AddrW = $clog2(Depth);
    localparam int RowW  = $clog2(PANEL_ROWS);
    localparam int ColW  = $clog2(PANEL_COLUMNS);

    cfg_t cfg;

    rled_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    seq_t st_reg, st_next;
    link_t link_reg, link_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] b1_reg, b1_next;
    logic [14:0] colour_reg, colour_next;
    logic [7:0] pcol_reg, pcol_next;
    logic [7:0] prow_reg, prow_next;
    logic [RowW-1:0] scan_row_reg, scan_row_next;
    logic [4:0] pwm_reg, pwm_next;
    logic [ColW:0] col_reg, col_next;
    logic [7:0] sh0_reg, sh0_next, sh1_reg, sh1_next, sh2_reg, sh2_next;
    logic out_valid_reg, out_valid_next;
    out_item_t out_reg, out_next;

    logic [14:0] mem [Depth];
    logic [Depth-1:0] vld_reg;
    logic [14:0] rd_q;
    logic rd_vld_q;
    logic we;
    logic [AddrW-1:0] waddr, raddr;

    logic accept;
    logic out_held;
    assign in_stall = (st_reg != ST_IDLE);
    assign accept = in_valid && !in_stall;
    assign out_held = out_valid_reg && out_stall;

    // window unit shared by painting
    logic [7:0] wcol, wrow, pcol_inc, prow_inc;
    logic in_win;
    assign wcol = pcol_reg - cfg.board_column_offset;
    assign wrow = prow_reg - cfg.board_row_offset;
    assign in_win = (wcol < 8'(PANEL_COLUMNS)) && (wrow < 8'(PANEL_ROWS));
    assign pcol_inc = pcol_reg + 8'd1;
    assign prow_inc = prow_reg + 8'd1;
    assign waddr = AddrW'({wrow[RowW-1:0], wcol[ColW-1:0]});
    assign we = (st_reg == ST_PAINT) && in_win;
    assign raddr = AddrW'({scan_row_reg, col_reg[ColW-1:0]});

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= colour_reg;
        end
        rd_q <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            rd_vld_q <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                vld_reg[waddr] <= 1'b1;
            end
            rd_vld_q <= vld_reg[raddr];
        end
    end

    logic [14:0] px;
    logic [4:0] comp [3];
    assign px = rd_vld_q ? rd_q : 15'd0;
    assign comp[0] = 5'((px & RedMask) >> 10);
    assign comp[1] = 5'((px & GreenMask) >> 5);
    assign comp[2] = 5'(px & BlueMask);

    // next state
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE:
            begin
                if (accept && in_data.command)
                begin
                    st_next = ST_SCAN_RD;
                end
                else if (accept && link_reg == LINK_BYTE2 && len_reg != 8'd0)
                begin
                    st_next = ST_PAINT;
                end
            end
            ST_PAINT:
            begin
                if (len_reg == 8'd1 ||
                    (pcol_inc == cfg.grid_columns && prow_inc == cfg.grid_rows))
                begin
                    st_next = ST_IDLE;
                end
            end
            ST_SCAN_RD: st_next = ST_SCAN_PX;
            ST_SCAN_PX:
            begin
                if (col_reg == (ColW+1)'(PANEL_COLUMNS))
                begin
                    st_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // hold the finished row until the result register frees
                if (!out_held)
                begin
                    st_next = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        logic [4:0] idx;
        logic [4:0] lb;
        link_next      = link_reg;
        len_next       = len_reg;
        b1_next        = b1_reg;
        colour_next    = colour_reg;
        pcol_next      = pcol_reg;
        prow_next      = prow_reg;
        scan_row_next  = scan_row_reg;
        pwm_next       = pwm_reg;
        col_next       = col_reg;
        sh0_next       = sh0_reg;
        sh1_next       = sh1_reg;
        sh2_next       = sh2_reg;
        out_valid_next = out_held;
        out_next       = out_reg;
        idx = 5'd0;
        lb  = 5'd0;
        case (st_reg)
            ST_IDLE:
            begin
                if (accept && in_data.command)
                begin
                    if (scan_row_reg == '0)
                    begin
                        pwm_next = (pwm_reg + 5'd1) & CompMask;
                    end
                    col_next = '0;
                    sh0_next = 8'd0;
                    sh1_next = 8'd0;
                    sh2_next = 8'd0;
                end
                else if (accept)
                begin
                    case (link_reg)
                        LINK_WAIT:
                            link_next = (in_data.data_byte == cfg.sync_first)
                                ? LINK_SYNC1 : LINK_WAIT;
                        LINK_SYNC1:
                            link_next = (in_data.data_byte == cfg.sync_second)
                                ? LINK_SYNC2 : LINK_WAIT;
                        LINK_SYNC2:
                        begin
                            if (in_data.data_byte == cfg.sync_third)
                            begin
                                link_next = LINK_BYTE0;
                                pcol_next = 8'd0;
                                prow_next = 8'd0;
                            end
                            else
                            begin
                                link_next = LINK_WAIT;
                            end
                        end
                        LINK_BYTE0:
                        begin
                            len_next  = in_data.data_byte;
                            link_next = LINK_BYTE1;
                        end
                        LINK_BYTE1:
                        begin
                            b1_next   = in_data.data_byte;
                            link_next = LINK_BYTE2;
                        end
                        LINK_BYTE2:
                        begin
                            colour_next = {b1_reg[6:0], in_data.data_byte};
                            link_next = (len_reg == 8'd0) ? LINK_WAIT : LINK_BYTE0;
                        end
                        default: link_next = LINK_WAIT;
                    endcase
                end
            end
            ST_PAINT:
            begin
                len_next = len_reg - 8'd1;
                if (pcol_inc == cfg.grid_columns)
                begin
                    pcol_next = 8'd0;
                    prow_next = prow_inc;
                    if (prow_inc == cfg.grid_rows)
                    begin
                        link_next = LINK_WAIT;
                    end
                end
                else
                begin
                    pcol_next = pcol_inc;
                end
            end
            ST_SCAN_RD:
            begin
                col_next = col_reg + (ColW+1)'(1);
            end
            ST_SCAN_PX:
            begin
                // the pixel on the read port is column col_reg - 1
                for (int c = 0; c < 3; c++)
                begin
                    idx = 5'((col_reg - (ColW+1)'(1)) * 3 + c);
                    lb  = lamp_map(idx);
                    if (pwm_reg < comp[c])
                    begin
                        case (lb[4:3])
                            2'd0: sh0_next[lb[2:0]] = 1'b1;
                            2'd1: sh1_next[lb[2:0]] = 1'b1;
                            default: sh2_next[lb[2:0]] = 1'b1;
                        endcase
                    end
                end
                col_next = col_reg + (ColW+1)'(1);
            end
            ST_OUT:
            begin
                if (!out_held)
                begin
                    out_valid_next = 1'b1;
                    out_next.shift_first  = sh0_reg;
                    out_next.shift_second = sh1_reg;
                    out_next.shift_third  = sh2_reg;
                    out_next.row_lit = (sh0_reg | sh1_reg | sh2_reg) != 8'd0;
                    out_next.row_drive = 8'd0;
                    if (out_next.row_lit)
                    begin
                        if (scan_row_reg < RowW'(4))
                        begin
                            out_next.row_drive = 8'(1) << (RowW'(3) - scan_row_reg);
                        end
                        else
                        begin
                            out_next.row_drive = 8'(1) << scan_row_reg;
                        end
                    end
                    scan_row_next = scan_row_reg + RowW'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            link_reg      <= LINK_WAIT;
            pcol_reg      <= 8'd0;
            prow_reg      <= 8'd0;
            scan_row_reg  <= '0;
            pwm_reg       <= 5'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            link_reg      <= link_next;
            pcol_reg      <= pcol_next;
            prow_reg      <= prow_next;
            scan_row_reg  <= scan_row_next;
            pwm_reg       <= pwm_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg    <= len_next;
        b1_reg     <= b1_next;
        colour_reg <= colour_next;
        col_reg    <= col_next;
        sh0_reg    <= sh0_next;
        sh1_reg    <= sh1_next;
        sh2_reg    <= sh2_next;
        out_reg    <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg && $stable(out_reg))
        else $error("result changed while stalled");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg != ST_IDLE |-> in_stall)
        else $error("input taken while busy");
    a_lit_drive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.row_lit ? $onehot(out_reg.row_drive)
                                           : out_reg.row_drive == 8'd0))
        else $error("row drive inconsistent with lit flag");
    a_paint_link: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == ST_PAINT |-> link_reg == LINK_BYTE0)
        else $error("painting outside frame phase");

endmodule

FILE: rtl/rled_cfg_regs.sv
// Configuration register file for the LED matrix driver.
// Depends on rled_pkg.
`timescale 1ns / 1ps
module rled_cfg_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [rled_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [rled_pkg::CfgDataW-1:0] cfg_data,
    output rled_pkg::cfg_t                cfg
);
    import rled_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{8'd0, 8'd0, 8'd0, 8'd8, 8'd8, 8'd0, 8'd0};
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SYNC_FIRST:  cfg_reg.sync_first          <= cfg_data;
                REG_SYNC_SECOND: cfg_reg.sync_second         <= cfg_data;
                REG_SYNC_THIRD:  cfg_reg.sync_third          <= cfg_data;
                REG_GRID_COLS:   cfg_reg.grid_columns        <= cfg_data;
                REG_GRID_ROWS:   cfg_reg.grid_rows           <= cfg_data;
                REG_BOARD_COL:   cfg_reg.board_column_offset <= cfg_data;
                REG_BOARD_ROW:   cfg_reg.board_row_offset    <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: tb/rle_pixel_stream_led_matrix_driver_unit_chk.sv
// Checker for the RLE pixel stream LED matrix driver: watches the input, output
// and register channels, predicts each refresh result and compares. Uses rled_pkg.
`timescale 1ns / 1ps
module rle_pixel_stream_led_matrix_driver_unit_chk
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  rled_pkg::in_item_t            in_data,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  rled_pkg::out_item_t           out_data,
    input  logic                          cfg_write,
    input  logic [rled_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [rled_pkg::CfgDataW-1:0] cfg_data,
    output int                            fail_count,
    output int                            pending_scans
);
    import rled_pkg::*;

    cfg_t        regs;
    link_t       phase;
    logic [7:0]  frame_bytes [3];
    logic [7:0]  ptr_col;
    logic [7:0]  ptr_row;
    logic [14:0] pixels [64];
    logic [2:0]  scan_row;
    logic [4:0]  pwm_slot;
    out_item_t   scan_queue [$];

    assign pending_scans = scan_queue.size();

    task automatic paint_run();
        logic [7:0]  run_len;
        logic [14:0] colour;
        logic [7:0]  wc;
        logic [7:0]  wr;
        run_len = frame_bytes[0];
        colour = {frame_bytes[1][6:0], frame_bytes[2]};
        phase = LINK_BYTE0;
        if (run_len == 0)
        begin
            phase = LINK_WAIT;
            return;
        end
        while (run_len != 0)
        begin
            wc = ptr_col - regs.board_column_offset;
            wr = ptr_row - regs.board_row_offset;
            run_len--;
            if (wr < 8 && wc < 8)
                pixels[{wr[2:0], wc[2:0]}] = colour;
            ptr_col++;
            if (ptr_col == regs.grid_columns)
            begin
                ptr_col = 0;
                ptr_row++;
                if (ptr_row == regs.grid_rows)
                begin
                    phase = LINK_WAIT;
                    return;
                end
            end
        end
    endtask

    task automatic take_byte(input logic [7:0] b);
        if (phase < LINK_BYTE0)
        begin
            if (phase == LINK_WAIT && b == regs.sync_first)
                phase = LINK_SYNC1;
            else if (phase == LINK_SYNC1 && b == regs.sync_second)
                phase = LINK_SYNC2;
            else if (phase == LINK_SYNC2 && b == regs.sync_third)
            begin
                phase = LINK_BYTE0;
                ptr_col = 0;
                ptr_row = 0;
            end
            else
                phase = LINK_WAIT;
            return;
        end
        frame_bytes[phase - LINK_BYTE0] = b;
        if (phase == LINK_BYTE2)
            paint_run();
        else
            phase = link_t'(phase + 1);
    endtask

    function automatic out_item_t scan_row_result();
        logic [7:0]  shift [3];
        logic [14:0] px;
        logic [4:0]  comp [3];
        logic [4:0]  lb;
        out_item_t   r;
        shift[0] = 0;
        shift[1] = 0;
        shift[2] = 0;
        if (scan_row == 0)
            pwm_slot = pwm_slot + 1;
        for (int col = 0; col < 8; col++)
        begin
            px = pixels[{scan_row, col[2:0]}];
            comp[0] = px[14:10];
            comp[1] = px[9:5];
            comp[2] = px[4:0];
            for (int c = 0; c < 3; c++)
            begin
                if (pwm_slot < comp[c])
                begin
                    lb = lamp_map(5'(col * 3 + c));
                    shift[lb[4:3]][lb[2:0]] = 1'b1;
                end
            end
        end
        r.row_lit = (shift[0] | shift[1] | shift[2]) != 0;
        r.row_drive = 0;
        if (r.row_lit)
            r.row_drive[scan_row < 4 ? 3 - scan_row : scan_row] = 1'b1;
        r.shift_first = shift[0];
        r.shift_second = shift[1];
        r.shift_third = shift[2];
        scan_row++;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            regs = '0;
            regs.grid_columns = 8;
            regs.grid_rows = 8;
            phase = LINK_WAIT;
            ptr_col = 0;
            ptr_row = 0;
            for (int i = 0; i < 64; i++)
                pixels[i] = 0;
            scan_row = 0;
            pwm_slot = 0;
            fail_count = 0;
            scan_queue.delete();
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_SYNC_FIRST:  regs.sync_first = cfg_data;
                    REG_SYNC_SECOND: regs.sync_second = cfg_data;
                    REG_SYNC_THIRD:  regs.sync_third = cfg_data;
                    REG_GRID_COLS:   regs.grid_columns = cfg_data;
                    REG_GRID_ROWS:   regs.grid_rows = cfg_data;
                    REG_BOARD_COL:   regs.board_column_offset = cfg_data;
                    REG_BOARD_ROW:   regs.board_row_offset = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                if (in_data.command)
                    scan_queue.push_back(scan_row_result());
                else
                    take_byte(in_data.data_byte);
            end
            if (out_valid && !out_stall)
            begin
                if (scan_queue.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h", $time,
                             out_data);
                    fail_count++;
                end
                else
                begin
                    want = scan_queue.pop_front();
                    if (want !== out_data)
                    begin
                        $display("%0t: row result expected %h, actual %h", $time, want,
                                 out_data);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

FILE: tb/rle_pixel_stream_led_matrix_driver_unit_tb.sv
// Testbench top for the RLE pixel stream LED matrix driver: drives stream bytes,
// refresh ticks and register writes. Depends on rled_pkg, the DUT and the checker.
`timescale 1ns / 1ps
module rle_pixel_stream_led_matrix_driver_unit_tb;
    import rled_pkg::*;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    in_item_t in_data;
    logic out_valid;
    logic out_stall;
    out_item_t out_data;
    logic cfg_write;
    logic [CfgIdxW-1:0] cfg_index;
    logic [CfgDataW-1:0] cfg_data;
    int fail_count;
    int pending_scans;
    int idle_cycles;
    bit no_stall_phase;
    logic [7:0] sync_seq [3];

    rle_pixel_stream_led_matrix_driver_unit i_dut (.*);

    rle_pixel_stream_led_matrix_driver_unit_chk i_chk (.*);

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // valid stays high after a transfer only when the next item follows at once
    task automatic send(input logic cmd, input logic [7:0] b);
        int gap;
        gap = no_stall_phase ? 0 : $urandom_range(0, 14);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{command: cmd, data_byte: b};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_scans != 0)
            @(posedge clk);
        // a long run can still be painting after the last result
        repeat (300) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [7:0] v);
        in_valid <= 1'b0;
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        if (idx == REG_SYNC_FIRST)
            sync_seq[0] = v;
        if (idx == REG_SYNC_SECOND)
            sync_seq[1] = v;
        if (idx == REG_SYNC_THIRD)
            sync_seq[2] = v;
    endtask

    task automatic send_sync();
        for (int i = 0; i < 3; i++)
            send(1'b0, sync_seq[i]);
    endtask

    task automatic send_frame(input logic [7:0] len, input logic [15:0] colour);
        send(1'b0, len);
        send(1'b0, colour[15:8]);
        send(1'b0, colour[7:0]);
    endtask

    task automatic random_phase(input int n_items);
        int k;
        k = 0;
        while (k < n_items)
        begin
            case ($urandom_range(0, 9))
                0: send(1'b0, 8'($urandom));
                1, 2, 3:
                begin
                    send(1'b1, 8'($urandom));
                    k++;
                end
                default:
                begin
                    send_sync();
                    k += 3;
                    repeat ($urandom_range(1, 6))
                    begin
                        if ($urandom_range(0, 15) == 0)
                            send_frame(8'd0, 16'($urandom));
                        else
                            send_frame($urandom_range(0, 3) == 0 ? 8'($urandom)
                                       : 8'($urandom_range(1, 12)), 16'($urandom));
                        k += 3;
                        repeat ($urandom_range(0, 3))
                        begin
                            send(1'b1, 8'($urandom));
                            k++;
                        end
                    end
                end
            endcase
        end
    endtask

    // watchdog on accepted transfers
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("rle_pixel_stream_led_matrix_driver_unit: mismatch");
            $finish;
        end
    end

    // receiver stall: random per result, with calm stretches
    initial
    begin
        int hold;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                hold = no_stall_phase ? 0 : $urandom_range(0, 14);
                if (hold != 0)
                begin
                    out_stall <= 1'b1;
                    repeat (hold) @(posedge clk);
                    out_stall <= 1'b0;
                end
            end
            else if (!no_stall_phase && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_data <= '0;
        cfg_write <= 1'b0;
        cfg_index <= REG_SYNC_FIRST;
        cfg_data <= '0;
        no_stall_phase = 0;
        sync_seq[0] = 0;
        sync_seq[1] = 0;
        sync_seq[2] = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: default registers, all-zero sync
        send(1'b1, 8'h00);
        send_sync();
        send_frame(8'd1, 16'hFFFF);
        send_frame(8'd0, 16'h1234);
        send(1'b0, 8'h55);
        send_sync();
        send_frame(8'd255, 16'h7FFF);
        send_frame(8'd3, 16'h8000);
        repeat (9) send(1'b1, 8'hFF);
        drain();

        write_reg(REG_SYNC_FIRST, 8'hFF);
        write_reg(REG_SYNC_SECOND, 8'hA5);
        write_reg(REG_SYNC_THIRD, 8'h5A);
        write_reg(REG_GRID_COLS, 8'd255);
        write_reg(REG_GRID_ROWS, 8'd255);
        write_reg(REG_BOARD_COL, 8'd250);
        write_reg(REG_BOARD_ROW, 8'd0);
        send(1'b0, 8'hFF);
        send(1'b0, 8'h00);
        send_sync();
        send_frame(8'd255, 16'h7C1F);
        send_frame(8'd20, 16'h03E0);
        repeat (8) send(1'b1, 8'h00);
        drain();

        // wrapping grid: zero size and high offsets
        write_reg(REG_GRID_COLS, 8'd0);
        write_reg(REG_GRID_ROWS, 8'd1);
        write_reg(REG_BOARD_COL, 8'd255);
        write_reg(REG_BOARD_ROW, 8'd255);
        random_phase(60);
        drain();

        write_reg(REG_GRID_COLS, 8'd1);
        write_reg(REG_GRID_ROWS, 8'd0);
        write_reg(REG_BOARD_COL, 8'd0);
        write_reg(REG_BOARD_ROW, 8'd0);
        random_phase(60);
        drain();

        for (int p = 0; p < 6; p++)
        begin
            write_reg(REG_SYNC_FIRST, 8'($urandom));
            write_reg(REG_SYNC_SECOND, 8'($urandom));
            write_reg(REG_SYNC_THIRD, 8'($urandom));
            write_reg(REG_GRID_COLS, 8'($urandom_range(4, 20)));
            write_reg(REG_GRID_ROWS, 8'($urandom_range(4, 20)));
            write_reg(REG_BOARD_COL, 8'($urandom_range(0, 8)));
            write_reg(REG_BOARD_ROW, 8'($urandom_range(0, 8)));
            no_stall_phase = (p == 3);
            random_phase(110);
            no_stall_phase = 0;
            drain();
        end

        while (pending_scans != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (fail_count == 0)
            $display("rle_pixel_stream_led_matrix_driver_unit: match");
        else
            $display("rle_pixel_stream_led_matrix_driver_unit: mismatch");
        $finish;
    end

endmodule

FILE: files.f
rtl/rled_pkg.sv
rtl/rled_cfg_regs.sv
rtl/rle_pixel_stream_led_matrix_driver_unit.sv
tb/rle_pixel_stream_led_matrix_driver_unit_chk.sv
tb/rle_pixel_stream_led_matrix_driver_unit_tb.sv
